### hw/rtl/epsp_pkg.sv
// Shared types and constants for the encoder speed PID and PWM duty block.
package epsp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] CFG_DERIV_GAIN = 2'd2;
    localparam logic [1:0] CFG_PWM_PERIOD = 2'd3;

    // Register reset values.
    localparam logic [9:0]  PROP_GAIN_RST  = 10'd8;
    localparam logic [9:0]  INTEG_GAIN_RST = 10'd1;
    localparam logic [9:0]  DERIV_GAIN_RST = 10'd10;
    localparam logic [15:0] PWM_PERIOD_RST = 16'd8000;

    // Shared multiplier: signed A operand times unsigned B operand.
    localparam int MUL_A_W = 23;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

    // Division by five through a reciprocal: q = (y * RECIP_5) >> RECIP_SHIFT.
    // Exact for every y below 2**22.
    localparam int                 RECIP_SHIFT = 26;
    localparam logic [MUL_B_W-1:0] RECIP_5     = 24'd13421773;

    // Input kinds carried in tuser.
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_I,
        ST_DIV,
        ST_INTEG,
        ST_SUM
    } t_state;

endpackage

### hw/rtl/epsp_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module epsp_mul
    import epsp_pkg::*;
(
    input  logic                       i_clk,
    input  logic signed [MUL_A_W-1:0]  i_a,
    input  logic        [MUL_B_W-1:0]  i_b,
    output logic signed [MUL_P_W-1:0]  o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;
    logic signed [MUL_P_W-1:0] n_prod;

    // The B operand is zero-extended so that the product stays signed.
    assign n_prod = MUL_P_W'(i_a) * MUL_P_W'($signed({1'b0, i_b}));

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/encoder_pid_speed_pwm.sv
// Top level: encoder edge counter, PID sequencer on a shared multiplier, duty output.
//
//  Channel | Direction | Handshake                       | Payload
//  s_axis  | in        | i_s_axis_tvalid/o_s_axis_tready | tdata: direction, setpoint; tuser: action
//  m_axis  | out       | o_m_axis_tvalid/i_m_axis_tready | tdata: duty, measured_speed
//  cfg     | in        | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// An encoder edge does not leave the idle state, so the block stays ready for the next item.
// A control tick holds off the next transfer while the sequencer makes four passes
// through the one shared multiplier (P, D, integral product, divide by 40), then
// does the integral update and the clamped duty sum.
// A full output register holds the sequencer in its last step until it is taken.
// Reset is synchronous, active low; the counter, PID state and duty clear to zero.
module encoder_pid_speed_pwm
    import epsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] direction, [4:1] setpoint, [7:5] zero
    input  logic        i_s_axis_tuser,   // [0] action
    // Result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] duty, [31:16] measured_speed
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int ERR_W  = 17;
    localparam int DIFF_W = 18;
    localparam int P_W    = 27;
    localparam int D_W    = 32;
    localparam int PD_W   = 33;
    localparam int Q_W    = 20;
    localparam int SUM_W  = 35;

    // Configuration registers
    logic [9:0]  r_prop_gain;
    logic [9:0]  r_integ_gain;
    logic [9:0]  r_deriv_gain;
    logic [15:0] r_pwm_period;

    // Controller state
    t_state                    r_state, n_state;
    logic signed [15:0]        r_edge_count;
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [31:0]        r_integ;
    logic        [15:0]        r_duty;

    // Per-tick working registers
    logic signed [15:0]        r_speed;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [P_W-1:0]     r_p;
    logic signed [D_W-1:0]     r_d;
    logic signed [PD_W-1:0]    r_pd;
    logic                      r_xneg;

    // Output register
    logic                      r_out_valid;
    logic [31:0]               r_out_data;

    // Shared multiplier operands and product
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    logic                      in_xfer;
    logic                      out_free;
    logic        [15:0]        kd40;
    logic        [15:0]        period_eff;
    logic signed [16:0]        speed_mag;
    logic signed [ERR_W-1:0]   err_new;
    logic signed [DIFF_W-1:0]  err_diff;
    logic signed [P_W-1:0]     x_prod;
    logic        [P_W-1:0]     x_abs;
    logic        [21:0]        y_div;
    logic        [Q_W-1:0]     q_div;
    logic signed [Q_W:0]       inc;
    logic signed [32:0]        integ_sum;
    logic signed [31:0]        integ_next;
    logic signed [SUM_W-1:0]   duty_sum;
    logic        [15:0]        duty_next;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Derivative gain scaled by 40 as two shifts.
    assign kd40 = 16'({r_deriv_gain, 5'd0}) + 16'({r_deriv_gain, 3'd0});

    // A period below two behaves as two.
    assign period_eff = (r_pwm_period < 16'd2) ? 16'd2 : r_pwm_period;

    // Error from the edge count at the tick.
    assign speed_mag = r_edge_count[15] ? -17'(r_edge_count) : 17'(r_edge_count);
    assign err_new   = $signed(ERR_W'({1'b0, i_s_axis_tdata[4:1]})) - speed_mag;
    assign err_diff  = DIFF_W'(r_err) - DIFF_W'(r_last_err);

    // Integral product magnitude; |x|/40 is (|x|>>3)/5.
    assign x_prod = mul_prod[P_W-1:0];
    assign x_abs  = x_prod[P_W-1] ? P_W'(-x_prod) : P_W'(x_prod);
    assign y_div  = x_abs[24:3];
    assign q_div  = mul_prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
    assign inc    = r_xneg ? -$signed({1'b0, q_div}) : $signed({1'b0, q_div});

    // Saturating integral update.
    assign integ_sum = 33'(r_integ) + 33'(inc);
    always_comb begin
        if (integ_sum[32] != integ_sum[31]) begin
            integ_next = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            integ_next = integ_sum[31:0];
        end
    end

    // Duty sum and clamp; the upper bound wins over the lower one.
    assign duty_sum = SUM_W'(r_pd) + SUM_W'(r_integ) + $signed(SUM_W'({1'b0, r_duty}));
    always_comb begin
        if (duty_sum >= $signed(SUM_W'({1'b0, period_eff}))) begin
            duty_next = period_eff - 16'd1;
        end else if (duty_sum <= 0) begin
            duty_next = 16'd1;
        end else begin
            duty_next = duty_sum[15:0];
        end
    end

    // Sequencer next state and multiplier operand selection.
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_s_axis_tuser == ACT_TICK)) begin
                    n_state = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                mul_a   = MUL_A_W'(r_err);
                mul_b   = MUL_B_W'(r_prop_gain);
                n_state = ST_MUL_D;
            end
            ST_MUL_D: begin
                mul_a   = MUL_A_W'(err_diff);
                mul_b   = MUL_B_W'(kd40);
                n_state = ST_MUL_I;
            end
            ST_MUL_I: begin
                mul_a   = MUL_A_W'(r_err);
                mul_b   = MUL_B_W'(r_integ_gain);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                mul_a   = $signed({1'b0, y_div});
                mul_b   = RECIP_5;
                n_state = ST_INTEG;
            end
            ST_INTEG: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_pwm_period <= PWM_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[9:0];
                CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data[9:0];
                CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[9:0];
                CFG_PWM_PERIOD: r_pwm_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Edge counter and PID state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_last_err   <= '0;
            r_integ      <= '0;
            r_duty       <= '0;
        end else begin
            if (in_xfer) begin
                if (i_s_axis_tuser == ACT_TICK) begin
                    r_edge_count <= '0;
                end else if (i_s_axis_tdata[0]) begin
                    if (r_edge_count != 16'sh7FFF) begin
                        r_edge_count <= r_edge_count + 16'sd1;
                    end
                end else if (r_edge_count != 16'sh8000) begin
                    r_edge_count <= r_edge_count - 16'sd1;
                end
            end
            if (r_state == ST_INTEG) begin
                r_integ <= integ_next;
            end
            if ((r_state == ST_SUM) && out_free) begin
                r_duty     <= duty_next;
                r_last_err <= r_err;
            end
        end
    end

    // Per-tick working registers capture each registered product in the step after the one that set its operands.
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_s_axis_tuser == ACT_TICK)) begin
            r_speed <= r_edge_count;
            r_err   <= err_new;
        end
        if (r_state == ST_MUL_D) begin
            r_p <= mul_prod[P_W-1:0];
        end
        if (r_state == ST_MUL_I) begin
            r_d <= mul_prod[D_W-1:0];
        end
        if (r_state == ST_DIV) begin
            r_xneg <= x_prod[P_W-1];
            r_pd   <= PD_W'(r_p) + PD_W'(r_d);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_SUM) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SUM) && out_free) begin
            r_out_data <= {r_speed, duty_next};
        end
    end

    epsp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // A tick clears the edge count and occupies the sequencer.
    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_s_axis_tuser == ACT_TICK)) |=> (r_edge_count == 0) && !o_s_axis_tready)
        else $error("tick did not clear the count or start the sequencer");

    // A delivered duty value is never zero.
    a_duty_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:0] != 16'd0))
        else $error("duty of zero presented");

    // The integral only moves in its own sequencer step.
    a_integ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_INTEG) |=> $stable(r_integ))
        else $error("integral changed outside its update step");

    // Edge items never give a result.
    a_edge_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_s_axis_tuser == ACT_EDGE) && !o_m_axis_tvalid) |=> !o_m_axis_tvalid)
        else $error("result appeared after an edge item");

endmodule
